@@ src/tpdose_pkg.sv @@
// shared types, constants and helpers for the two-pump ratio dosing controller
// no dependencies; used by the result and configuration interfaces, the top level and the testbench
package tpdose_pkg;

    // tick counter width and the width of a counter times a ratio digit
    localparam int COUNT_WIDTH = 32;
    localparam int PROD_WIDTH  = COUNT_WIDTH + 4;

    typedef logic [COUNT_WIDTH-1:0] cnt_t;
    typedef logic [PROD_WIDTH-1:0]  prod_t;
    typedef logic [1:0]             phase_t;
    typedef logic [3:0]             ratio_t;

    // phase codes
    localparam phase_t PH_WAIT_RATIO = 2'd0;
    localparam phase_t PH_WAIT_START = 2'd1;
    localparam phase_t PH_PUMP_ONE   = 2'd2;
    localparam phase_t PH_PUMP_TWO   = 2'd3;

    // command codes of an input word
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // configuration register indexes
    localparam int         CFG_IDX_WIDTH  = 2;
    localparam logic [1:0] CFG_START_CHAR = 2'd0;
    localparam logic [1:0] CFG_MAX_RATIO  = 2'd1;

    // ascii digits and the ratio scale
    localparam logic [7:0] CHAR_ONE   = 8'h31;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam ratio_t     RATIO_BASE = 4'd10;

    // reset values of the configuration registers
    localparam logic [7:0] START_CHAR_RST = 8'd57;
    localparam ratio_t     MAX_RATIO_RST  = 4'd5;

    // indicator and pump drives that belong to each phase
    typedef struct packed {
        logic red;
        logic yellow;
        logic green;
        logic pump_one;
        logic pump_two;
    } drive_t;

    function automatic drive_t phase_drive(input phase_t ph);
        drive_t d;
        d = '0;
        case (ph)
            PH_WAIT_RATIO:
            begin
                d.red    = 1'b1;
                d.yellow = 1'b1;
                d.green  = 1'b1;
            end
            PH_WAIT_START:
            begin
                d.red = 1'b1;
            end
            PH_PUMP_ONE:
            begin
                d.yellow   = 1'b1;
                d.pump_one = 1'b1;
            end
            PH_PUMP_TWO:
            begin
                d.green    = 1'b1;
                d.pump_two = 1'b1;
            end
            default:
            begin
                d = '0;
            end
        endcase
        return d;
    endfunction

endpackage

@@ src/dose_in_if.sv @@
// input channel: received bytes and time ticks with valid/ready
// no dependencies
interface dose_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] rx_byte;
    logic       level_full;

    modport source (output valid, output command, output rx_byte, output level_full,
                    input ready);
    modport sink (input valid, input command, input rx_byte, input level_full,
                  output ready);
endinterface

@@ src/dose_out_if.sv @@
// result channel: indicator, pump, phase and echo fields with valid/ready
// depends on tpdose_pkg for the phase type
interface dose_out_if;
    logic                 valid;
    logic                 ready;
    logic                 red_led;
    logic                 yellow_led;
    logic                 green_led;
    logic                 pump_one_on;
    logic                 pump_two_on;
    tpdose_pkg::phase_t   phase_now;
    logic                 echo_valid;
    logic [7:0]           echo_byte;

    modport source (output valid, output red_led, output yellow_led, output green_led,
                    output pump_one_on, output pump_two_on, output phase_now,
                    output echo_valid, output echo_byte, input ready);
    modport sink (input valid, input red_led, input yellow_led, input green_led,
                  input pump_one_on, input pump_two_on, input phase_now,
                  input echo_valid, input echo_byte, output ready);
endinterface

@@ src/dose_cfg_if.sv @@
// configuration write channel: register index and write data with valid/ready
// depends on tpdose_pkg for the index width
interface dose_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [tpdose_pkg::CFG_IDX_WIDTH-1:0]  index;
    logic [7:0]                            data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ src/two_pump_ratio_dosing_controller.sv @@
// two-pump ratio dosing controller, top level
// a word's result is registered at the edge that accepts the word
// throughput: one word per cycle while the result register is free; state and result register update in a single pass
// the output register frees for a new word whenever its result is taken in the same cycle
// reset (rst_n low, asynchronous): wait-for-ratio phase, counters cleared, start char 57,
// max ratio 5, no result pending
module two_pump_ratio_dosing_controller (
    input  logic            clk,
    input  logic            rst_n,
    dose_in_if.sink         in_ch,
    dose_out_if.source      out_ch,
    dose_cfg_if.sink        cfg
);

    // configuration registers
    logic [7:0]          start_char_reg;
    tpdose_pkg::ratio_t  max_ratio_reg;

    // controller state
    tpdose_pkg::phase_t  phase_reg, phase_next;
    tpdose_pkg::ratio_t  ratio_reg, ratio_next;
    tpdose_pkg::cnt_t    first_cnt_reg, first_cnt_next;
    tpdose_pkg::cnt_t    second_cnt_reg, second_cnt_next;
    // running products first_cnt*ratio and second_cnt*(10-ratio), kept by adding
    // the digit on each counted tick so the stop test is one add and compare
    tpdose_pkg::prod_t   first_prod_reg, first_prod_next;
    tpdose_pkg::prod_t   second_prod_reg, second_prod_next;

    // result register
    logic                out_valid_reg;
    tpdose_pkg::phase_t  out_phase_reg;
    logic                out_echo_valid_reg;
    logic [7:0]          out_echo_byte_reg;

    logic                in_fire;
    logic                digit_ok;
    tpdose_pkg::ratio_t  rest;
    tpdose_pkg::drive_t  drive;

    // the result register frees when empty or drained this cycle
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign cfg.ready   = 1'b1;

    // ascii '1'..'9' not above the limit; the low nibble is the digit value
    assign digit_ok = (in_ch.rx_byte >= tpdose_pkg::CHAR_ONE)
                   && (in_ch.rx_byte <= tpdose_pkg::CHAR_NINE)
                   && (in_ch.rx_byte[3:0] <= max_ratio_reg);

    assign rest = tpdose_pkg::RATIO_BASE - ratio_reg;

    // next state for the word at the input
    always_comb
    begin
        phase_next       = phase_reg;
        ratio_next       = ratio_reg;
        first_cnt_next   = first_cnt_reg;
        second_cnt_next  = second_cnt_reg;
        first_prod_next  = first_prod_reg;
        second_prod_next = second_prod_reg;
        if (in_ch.command == tpdose_pkg::CMD_BYTE)
        begin
            case (phase_reg)
                tpdose_pkg::PH_WAIT_RATIO:
                begin
                    if (digit_ok)
                    begin
                        ratio_next = in_ch.rx_byte[3:0];
                        phase_next = tpdose_pkg::PH_WAIT_START;
                    end
                end
                tpdose_pkg::PH_WAIT_START:
                begin
                    // start char clears both counters and their products
                    if (in_ch.rx_byte == start_char_reg)
                    begin
                        first_cnt_next   = '0;
                        second_cnt_next  = '0;
                        first_prod_next  = '0;
                        second_prod_next = '0;
                        phase_next       = tpdose_pkg::PH_PUMP_ONE;
                    end
                end
                default:
                begin
                    // bytes while pumping are only echoed
                end
            endcase
        end
        else
        begin
            case (phase_reg)
                tpdose_pkg::PH_PUMP_ONE:
                begin
                    // saturating count; a stuck counter stops its product too
                    if (first_cnt_reg != '1)
                    begin
                        first_cnt_next  = first_cnt_reg + 1'b1;
                        first_prod_next = first_prod_reg + tpdose_pkg::prod_t'(ratio_reg);
                    end
                    if (in_ch.level_full)
                        phase_next = tpdose_pkg::PH_PUMP_TWO;
                end
                tpdose_pkg::PH_PUMP_TWO:
                begin
                    if (second_cnt_reg != '1)
                    begin
                        second_cnt_next  = second_cnt_reg + 1'b1;
                        second_prod_next = second_prod_reg + tpdose_pkg::prod_t'(rest);
                    end
                    // second volume has passed its share of the first
                    if (second_prod_next > first_prod_reg)
                    begin
                        phase_next = tpdose_pkg::PH_WAIT_RATIO;
                        ratio_next = '0;
                    end
                end
                default:
                begin
                    // ticks while waiting change nothing
                end
            endcase
        end
    end

    // configuration writes; indexes beyond the list are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_char_reg <= tpdose_pkg::START_CHAR_RST;
            max_ratio_reg  <= tpdose_pkg::MAX_RATIO_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                tpdose_pkg::CFG_START_CHAR: start_char_reg <= cfg.data;
                tpdose_pkg::CFG_MAX_RATIO:  max_ratio_reg  <= cfg.data[3:0];
                default:                    ;
            endcase
        end
    end

    // controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= tpdose_pkg::PH_WAIT_RATIO;
            ratio_reg       <= '0;
            first_cnt_reg   <= '0;
            second_cnt_reg  <= '0;
            first_prod_reg  <= '0;
            second_prod_reg <= '0;
        end
        else if (in_fire)
        begin
            phase_reg       <= phase_next;
            ratio_reg       <= ratio_next;
            first_cnt_reg   <= first_cnt_next;
            second_cnt_reg  <= second_cnt_next;
            first_prod_reg  <= first_prod_next;
            second_prod_reg <= second_prod_next;
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    // result payload, shows the state after the word
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_phase_reg      <= phase_next;
            out_echo_valid_reg <= (in_ch.command == tpdose_pkg::CMD_BYTE);
            out_echo_byte_reg  <= (in_ch.command == tpdose_pkg::CMD_BYTE) ? in_ch.rx_byte
                                                                           : 8'd0;
        end
    end

    // indicator and pump drives follow the phase
    assign drive = tpdose_pkg::phase_drive(out_phase_reg);

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.red_led     = drive.red;
    assign out_ch.yellow_led  = drive.yellow;
    assign out_ch.green_led   = drive.green;
    assign out_ch.pump_one_on = drive.pump_one;
    assign out_ch.pump_two_on = drive.pump_two;
    assign out_ch.phase_now   = out_phase_reg;
    assign out_ch.echo_valid  = out_echo_valid_reg;
    assign out_ch.echo_byte   = out_echo_byte_reg;

endmodule

@@ sim/tb_two_pump_ratio_dosing_controller.sv @@
`timescale 1ns / 1ps
// testbench for the two-pump ratio dosing controller: directed and random words, a
// cycle-free predictor of the dosing sequence and an in-order check of every result word
// depends on tpdose_pkg, dose_in_if, dose_out_if, dose_cfg_if and the top level in src
module tb_two_pump_ratio_dosing_controller;

    // register indexes that the block does not decode, each written once before both registers are set again
    localparam logic [1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [1:0] CFG_SPARE_HI = 2'd3;
    // ascii '3', a start character that is also a ratio digit
    localparam logic [7:0] CHAR_THREE   = 8'h33;
    // keep a broken block from flooding the log
    localparam int unsigned MAX_PRINTED = 60;

    // one input word as the sender drives it
    typedef struct packed {
        logic       command;
        logic [7:0] rx_byte;
        logic       level_full;
    } dose_word_t;

    // one result word as the block should present it
    typedef struct packed {
        logic                red;
        logic                yellow;
        logic                green;
        logic                pump_one;
        logic                pump_two;
        tpdose_pkg::phase_t  phase_now;
        logic                echo_valid;
        logic [7:0]          echo_byte;
    } dose_result_t;

    logic clk;
    logic rst_n;

    dose_in_if  in_ch ();
    dose_out_if out_ch ();
    dose_cfg_if cfg ();

    two_pump_ratio_dosing_controller i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    // predicted controller state and its own copy of the two registers
    logic [7:0]          start_code;
    tpdose_pkg::ratio_t  ratio_limit;
    tpdose_pkg::phase_t  dose_phase;
    tpdose_pkg::ratio_t  dose_ratio;
    tpdose_pkg::cnt_t    fill_ticks;
    tpdose_pkg::cnt_t    mix_ticks;

    dose_word_t   pending_words[$];   // words waiting to be driven
    dose_result_t due_results[$];     // results owed by the block, oldest first
    int unsigned  mismatches;
    int unsigned  posted;

    // sender state; sending mirrors in_ch.valid but is updated at once,
    // so the stimulus thread never reads a stale flag at an edge
    logic         sending;
    dose_word_t   next_word;
    int unsigned  src_gap;
    int unsigned  src_stretch;
    logic         src_steady;

    // receiver state
    logic         taking;
    int unsigned  sink_hold;
    int unsigned  sink_stretch;
    logic         sink_steady;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // mostly short pauses, now and then a long one
    function automatic int unsigned pick_pause();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 45)
            return 0;
        else if (roll < 85)
            return $urandom_range(3, 1);
        else if (roll < 97)
            return $urandom_range(12, 4);
        else
            return $urandom_range(60, 20);
    endfunction

    task automatic note_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    // advance the predicted controller by one accepted word and queue the result it owes
    task automatic step_dosing(input dose_word_t w);
        dose_result_t        r;
        tpdose_pkg::ratio_t  digit;
        tpdose_pkg::prod_t   mix_side;
        tpdose_pkg::prod_t   fill_side;
        if (w.command == tpdose_pkg::CMD_BYTE)
        begin
            case (dose_phase)
                tpdose_pkg::PH_WAIT_RATIO:
                begin
                    // only '1'..'9' can set a ratio, whatever the limit says
                    if (w.rx_byte >= tpdose_pkg::CHAR_ONE && w.rx_byte <= tpdose_pkg::CHAR_NINE)
                    begin
                        digit = tpdose_pkg::ratio_t'(w.rx_byte - tpdose_pkg::CHAR_ONE) + 4'd1;
                        if (digit <= ratio_limit)
                        begin
                            dose_ratio = digit;
                            dose_phase = tpdose_pkg::PH_WAIT_START;
                        end
                    end
                end
                tpdose_pkg::PH_WAIT_START:
                begin
                    if (w.rx_byte == start_code)
                    begin
                        fill_ticks = '0;
                        mix_ticks  = '0;
                        dose_phase = tpdose_pkg::PH_PUMP_ONE;
                    end
                end
                default:
                begin
                    // bytes while pumping are only echoed
                end
            endcase
        end
        else
        begin
            case (dose_phase)
                tpdose_pkg::PH_PUMP_ONE:
                begin
                    if (fill_ticks != '1)
                        fill_ticks = fill_ticks + 1'b1;
                    if (w.level_full)
                        dose_phase = tpdose_pkg::PH_PUMP_TWO;
                end
                tpdose_pkg::PH_PUMP_TWO:
                begin
                    if (mix_ticks != '1)
                        mix_ticks = mix_ticks + 1'b1;
                    // stop once second*(10-ratio) passes first*ratio
                    mix_side  = tpdose_pkg::prod_t'(mix_ticks)
                              * tpdose_pkg::prod_t'(tpdose_pkg::RATIO_BASE - dose_ratio);
                    fill_side = tpdose_pkg::prod_t'(fill_ticks) * tpdose_pkg::prod_t'(dose_ratio);
                    if (mix_side > fill_side)
                    begin
                        dose_phase = tpdose_pkg::PH_WAIT_RATIO;
                        dose_ratio = '0;
                    end
                end
                default:
                begin
                    // ticks while waiting change nothing
                end
            endcase
        end

        r = '0;
        case (dose_phase)
            tpdose_pkg::PH_WAIT_RATIO:
            begin
                r.red    = 1'b1;
                r.yellow = 1'b1;
                r.green  = 1'b1;
            end
            tpdose_pkg::PH_WAIT_START:
            begin
                r.red = 1'b1;
            end
            tpdose_pkg::PH_PUMP_ONE:
            begin
                r.yellow   = 1'b1;
                r.pump_one = 1'b1;
            end
            default:
            begin
                r.green    = 1'b1;
                r.pump_two = 1'b1;
            end
        endcase
        r.phase_now  = dose_phase;
        r.echo_valid = (w.command == tpdose_pkg::CMD_BYTE);
        r.echo_byte  = (w.command == tpdose_pkg::CMD_BYTE) ? w.rx_byte : 8'd0;
        due_results.push_back(r);
    endtask

    // compare the word on the result channel with the oldest expectation
    task automatic check_result();
        dose_result_t want;
        if (due_results.size() == 0)
        begin
            note_mismatch("result with nothing expected", out_ch.echo_byte, 8'd0);
        end
        else
        begin
            want = due_results.pop_front();
            if (out_ch.red_led !== want.red)
                note_mismatch("red_led", 8'(out_ch.red_led), 8'(want.red));
            if (out_ch.yellow_led !== want.yellow)
                note_mismatch("yellow_led", 8'(out_ch.yellow_led), 8'(want.yellow));
            if (out_ch.green_led !== want.green)
                note_mismatch("green_led", 8'(out_ch.green_led), 8'(want.green));
            if (out_ch.pump_one_on !== want.pump_one)
                note_mismatch("pump_one_on", 8'(out_ch.pump_one_on), 8'(want.pump_one));
            if (out_ch.pump_two_on !== want.pump_two)
                note_mismatch("pump_two_on", 8'(out_ch.pump_two_on), 8'(want.pump_two));
            if (out_ch.phase_now !== want.phase_now)
                note_mismatch("phase_now", 8'(out_ch.phase_now), 8'(want.phase_now));
            if (out_ch.echo_valid !== want.echo_valid)
                note_mismatch("echo_valid", 8'(out_ch.echo_valid), 8'(want.echo_valid));
            if (out_ch.echo_byte !== want.echo_byte)
                note_mismatch("echo_byte", out_ch.echo_byte, want.echo_byte);
        end
    endtask

    // sender: predicts at each accepted word, then launches the next one after its gap
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                step_dosing({in_ch.command, in_ch.rx_byte, in_ch.level_full});
                sending = 1'b0;
            end
            if (!sending)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                end
                else if (pending_words.size() > 0)
                begin
                    next_word = pending_words.pop_front();
                    in_ch.command    <= next_word.command;
                    in_ch.rx_byte    <= next_word.rx_byte;
                    in_ch.level_full <= next_word.level_full;
                    sending = 1'b1;
                    // runs of back-to-back words alternate with gappy runs
                    if (src_stretch == 0)
                    begin
                        src_stretch = $urandom_range(40, 8);
                        src_steady  = ($urandom_range(3) == 0);
                    end
                    src_stretch--;
                    src_gap = src_steady ? 0 : pick_pause();
                end
            end
            in_ch.valid <= sending;
        end
    end

    // receiver: checks each taken result and stalls at random
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
                check_result();
            if (sink_hold > 0)
            begin
                sink_hold--;
                taking = 1'b0;
            end
            else
            begin
                if (sink_stretch == 0)
                begin
                    sink_stretch = $urandom_range(120, 20);
                    sink_steady  = ($urandom_range(3) == 0);
                end
                sink_stretch--;
                sink_hold = (!sink_steady && $urandom_range(3) == 0) ? pick_pause() : 0;
                taking    = (sink_hold == 0);
                if (sink_hold > 0)
                    sink_hold--;
            end
            out_ch.ready <= taking;
        end
    end

    function automatic dose_word_t tick_word(input logic lvl);
        dose_word_t w;
        w.command    = tpdose_pkg::CMD_TICK;
        w.rx_byte    = 8'($urandom_range(255));  // ignored on a tick, but keep it moving
        w.level_full = lvl;
        return w;
    endfunction

    function automatic dose_word_t byte_word(input logic [7:0] b);
        dose_word_t w;
        w.command    = tpdose_pkg::CMD_BYTE;
        w.rx_byte    = b;
        w.level_full = 1'($urandom_range(1));
        return w;
    endfunction

    function automatic dose_word_t noise_word();
        dose_word_t w;
        w.command    = 1'($urandom_range(1));
        w.rx_byte    = 8'($urandom_range(255));
        w.level_full = 1'($urandom_range(1));
        return w;
    endfunction

    task automatic post(input dose_word_t w);
        pending_words.push_back(w);
        posted++;
    endtask

    // nothing queued, nothing on the wire, nothing owed
    task automatic wait_drained();
        while (pending_words.size() != 0 || sending || due_results.size() != 0)
            @(posedge clk);
    endtask

    // a register write; the block takes it at the edge where valid and ready meet
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        if (idx == tpdose_pkg::CFG_START_CHAR)
            start_code = value;
        else if (idx == tpdose_pkg::CFG_MAX_RATIO)
            ratio_limit = value[3:0];
        cfg.valid <= 1'b0;
    endtask

    // both registers; the upper nibble of the ratio limit write is junk the block drops
    task automatic set_limits(input logic [7:0] start, input tpdose_pkg::ratio_t lim);
        logic [3:0] junk;
        junk = 4'($urandom_range(15));
        write_reg(tpdose_pkg::CFG_START_CHAR, start);
        write_reg(tpdose_pkg::CFG_MAX_RATIO, {junk, lim});
    endtask

    // one full dosing run with random noise, a random ratio digit and random fill length
    task automatic post_dosing_cycle();
        int unsigned digit;
        int unsigned top;
        int unsigned fill;
        int unsigned drain;
        logic [7:0]  code;
        repeat ($urandom_range(2))
            post(noise_word());
        top = (ratio_limit > 9) ? 9 : ratio_limit;
        // mostly a digit the limit accepts, sometimes '0'..':' at random
        if (top > 0 && $urandom_range(99) < 85)
            digit = $urandom_range(top, 1);
        else
            digit = $urandom_range(10, 0);
        code = tpdose_pkg::CHAR_ONE - 8'd1 + 8'(digit);
        post(byte_word(code));
        repeat ($urandom_range(2))
            post(noise_word());
        post(byte_word(start_code));
        // short fills usually, a long one now and then
        fill = ($urandom_range(9) == 0) ? $urandom_range(40, 7) : $urandom_range(6, 1);
        repeat (fill - 1)
        begin
            if ($urandom_range(9) == 0)
                post(byte_word(8'($urandom_range(255))));
            post(tick_word(1'b0));
        end
        post(tick_word(1'b1));
        // enough second-pump ticks to reach the ratio, plus a few spare ones
        if (digit >= 1 && digit <= 9)
            drain = fill * digit / (10 - digit) + 1;
        else
            drain = 1;
        drain += $urandom_range(2);
        repeat (drain)
            post(tick_word(1'($urandom_range(1))));
    endtask

    // random words in batches; the sender is kept fed, or held until all results are in
    task automatic run_random(input int unsigned count);
        int unsigned goal;
        int unsigned batch_end;
        goal = posted + count;
        while (posted < goal)
        begin
            batch_end = posted + $urandom_range(80, 20);
            while (posted < batch_end && posted < goal)
            begin
                if ($urandom_range(4) == 0)
                begin
                    repeat ($urandom_range(8, 1))
                        post(noise_word());
                end
                else
                begin
                    post_dosing_cycle();
                end
            end
            if ($urandom_range(3) == 0)
                wait_drained();
            else
                while (pending_words.size() > 4)
                    @(posedge clk);
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.command    = tpdose_pkg::CMD_BYTE;
        in_ch.rx_byte    = 8'd0;
        in_ch.level_full = 1'b0;
        out_ch.ready     = 1'b0;
        cfg.valid        = 1'b0;
        cfg.index        = tpdose_pkg::CFG_START_CHAR;
        cfg.data         = 8'd0;
        start_code       = tpdose_pkg::START_CHAR_RST;
        ratio_limit      = tpdose_pkg::MAX_RATIO_RST;
        dose_phase       = tpdose_pkg::PH_WAIT_RATIO;
        dose_ratio       = '0;
        fill_ticks       = '0;
        mix_ticks        = '0;
        mismatches       = 0;
        posted           = 0;
        sending          = 1'b0;
        src_gap          = 0;
        src_stretch      = 0;
        src_steady       = 1'b0;
        taking           = 1'b0;
        sink_hold        = 0;
        sink_stretch     = 0;
        sink_steady      = 1'b0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset registers, start char '9', ratio limit five
        post(tick_word(1'b1));                            // tick while waiting for a ratio
        post(byte_word(8'h00));                           // byte extremes, echo only
        post(byte_word(8'hFF));
        post(byte_word(tpdose_pkg::CHAR_ONE - 8'd1));     // '0' is no ratio
        post(byte_word(tpdose_pkg::CHAR_NINE + 8'd1));    // ':' neither
        post(byte_word(tpdose_pkg::CHAR_ONE + 8'd5));     // '6' is above the limit
        post(byte_word(tpdose_pkg::CHAR_ONE + 8'd4));     // '5' sets the ratio
        post(tick_word(1'b1));                            // tick while waiting for start
        post(byte_word(tpdose_pkg::CHAR_ONE));            // wrong byte while waiting for start
        post(byte_word(tpdose_pkg::START_CHAR_RST));      // pump one runs
        post(byte_word(tpdose_pkg::CHAR_ONE + 8'd2));     // byte while pump one runs
        post(tick_word(1'b0));
        post(tick_word(1'b0));
        post(tick_word(1'b1));                            // level reached on the third tick
        post(byte_word(tpdose_pkg::START_CHAR_RST));      // byte while pump two runs
        repeat (4)
            post(tick_word(1'($urandom_range(1))));       // 4*5 > 3*5 ends the run
        post(byte_word(tpdose_pkg::CHAR_ONE));            // smallest ratio
        post(byte_word(tpdose_pkg::START_CHAR_RST));
        post(tick_word(1'b1));
        post(tick_word(1'b0));                            // 1*9 > 1*1 ends at once
        wait_drained();

        run_random(250);

        // start char zero, every digit allowed
        set_limits(8'h00, 4'd9);
        run_random(150);

        // start char all ones, only '1'
        set_limits(8'hFF, 4'd1);
        run_random(120);

        // undecoded indexes, then a limit above nine and a start char that is a digit
        write_reg(CFG_SPARE_LO, 8'($urandom_range(255)));
        write_reg(CFG_SPARE_HI, 8'($urandom_range(255)));
        set_limits(CHAR_THREE, 4'd15);
        run_random(150);

        // limit zero: no digit gets through
        set_limits(8'($urandom_range(255)), 4'd0);
        run_random(80);

        set_limits(8'($urandom_range(255)), 4'($urandom_range(9, 1)));
        run_random(200);

        wait_drained();
        repeat (8)
            @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial
    begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

@@ sim.f @@
src/tpdose_pkg.sv
src/dose_in_if.sv
src/dose_out_if.sv
src/dose_cfg_if.sv
src/two_pump_ratio_dosing_controller.sv
sim/tb_two_pump_ratio_dosing_controller.sv
